/* hdl/amu_pkg.sv */
package amu_pkg;

  localparam int AMU_MEM_WORDS = 2048;
  localparam int ADDR_W        = 14;
  localparam int DATA_W        = 64;
  // Raw word index (address bits above the byte offset) plus one carry bit.
  localparam int RAW_IDX_W     = ADDR_W - 3 + 1;

  localparam logic [1:0] OP_FADD = 2'd0;
  localparam logic [1:0] OP_SWAP = 2'd1;
  localparam logic [1:0] OP_CAS  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [1:0] SIZE_32  = 2'd0;
  localparam logic [1:0] SIZE_64  = 2'd1;
  localparam logic [1:0] SIZE_128 = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_UNSUP    = 2'd1;
  localparam logic [1:0] STATUS_MISALIGN = 2'd2;

  // A request as held by the sequencer while it is being worked on.
  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        size_code;
    logic              lane_hi;
    logic [DATA_W-1:0] a_lo;
    logic [DATA_W-1:0] a_hi;
    logic [DATA_W-1:0] b_lo;
    logic [DATA_W-1:0] b_hi;
    logic [1:0]        status;
  } req_t;

  // What the modify logic hands back to the sequencer.
  typedef struct packed {
    logic              wr_lo;
    logic              wr_hi;
    logic [DATA_W-1:0] new_lo;
    logic [DATA_W-1:0] new_hi;
    logic [DATA_W-1:0] old_lo;
    logic [DATA_W-1:0] old_hi;
  } alu_res_t;

endpackage

/* hdl/amu_store.sv */
module amu_store import amu_pkg::*; #(
  parameter int  WORDS = AMU_MEM_WORDS,
  localparam int AW    = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr0,
  input  logic [AW-1:0]     raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata0_r;
  logic [DATA_W-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports, data registered; reads and writes never share a cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

/* hdl/amu_alu.sv */
module amu_alu import amu_pkg::*; (
  input  req_t              req,
  input  logic [DATA_W-1:0] rd_lo,
  input  logic [DATA_W-1:0] rd_hi,
  output alu_res_t          res
);

  logic [31:0] old32;
  logic [31:0] nv32;
  logic [63:0] nv64;
  logic        match128;

  always_comb begin
    old32 = req.lane_hi ? rd_lo[63:32] : rd_lo[31:0];

    case (req.op)
      OP_FADD: nv32 = old32 + req.a_lo[31:0];
      OP_SWAP: nv32 = req.a_lo[31:0];
      default: nv32 = (old32 == req.a_lo[31:0]) ? req.b_lo[31:0] : old32;
    endcase

    case (req.op)
      OP_FADD: nv64 = rd_lo + req.a_lo;
      OP_SWAP: nv64 = req.a_lo;
      default: nv64 = (rd_lo == req.a_lo) ? req.b_lo : rd_lo;
    endcase

    match128 = (rd_lo == req.a_lo) && (rd_hi == req.a_hi);

    res = '0;
    if (req.status == STATUS_OK) begin
      case (req.size_code)
        SIZE_32: begin
          res.wr_lo  = 1'b1;
          res.new_lo = req.lane_hi ? {nv32, rd_lo[31:0]} : {rd_lo[63:32], nv32};
          res.old_lo = {32'd0, old32};
        end
        SIZE_64: begin
          res.wr_lo  = 1'b1;
          res.new_lo = nv64;
          res.old_lo = rd_lo;
        end
        default: begin
          res.old_lo = rd_lo;
          res.old_hi = rd_hi;
          if (req.op == OP_SWAP) begin
            res.wr_lo  = 1'b1;
            res.wr_hi  = 1'b1;
            res.new_lo = req.a_lo;
            res.new_hi = req.a_hi;
          end else if (req.op == OP_CAS && match128) begin
            res.wr_lo  = 1'b1;
            res.wr_hi  = 1'b1;
            res.new_lo = req.b_lo;
            res.new_hi = req.b_hi;
          end
        end
      endcase
    end
  end

endmodule

/* hdl/fabric_atomic_memory_unit.sv */
// Memory-side atomic unit over a store of MEM_WORDS 64-bit words.
// The request channel (in_valid / in_stall) carries an operation, a size, a
// byte address and two 128-bit operands. The result channel (out_valid /
// out_stall) returns the value held at the target before the request, plus a
// status: ok, unsupported operation and size, or misaligned address.
// Requests are worked on one at a time. A request is taken in the idle state,
// which also issues the memory read of the target word(s). The modify step
// that follows modifies the data, loads the result register and writes the low
// word back; a 128-bit swap or a 128-bit compare-and-store writes its high word
// in a further write step. The unit takes no new request until it is through
// with the last one, and a 128-bit write needs that extra step because the
// store has a single write port.
// The result sits in an output register, so a new request is taken while
// the previous result still waits. If the receiver stalls and that register
// is still full when the next result is ready, the unit holds in its modify
// step until the register drains.
// After reset the store is swept to zero, one word per cycle; in_stall stays
// high during the sweep.
module fabric_atomic_memory_unit import amu_pkg::*; #(
  parameter int MEM_WORDS = AMU_MEM_WORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [1:0]        in_size_code,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_operand_a_lo,
  input  logic [DATA_W-1:0] in_operand_a_hi,
  input  logic [DATA_W-1:0] in_operand_b_lo,
  input  logic [DATA_W-1:0] in_operand_b_hi,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_old_lo,
  output logic [DATA_W-1:0] out_old_hi,
  output logic [1:0]        out_status
);

  localparam int AW = $clog2(MEM_WORDS);
  // Word index reduction: conditional subtracts of MEM_WORDS scaled by
  // powers of two, covering every raw index up to the top of the address map.
  localparam int RAW_MAX = 1 << (RAW_IDX_W - 1);
  localparam int RATIO   = (RAW_MAX + 1) / MEM_WORDS;
  localparam int NSTEP   = $clog2(RATIO + 1);
  localparam int VW      = AW + RAW_IDX_W + 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_WRH  = 2'd3;

  function automatic logic [AW-1:0] reduce_idx(input logic [RAW_IDX_W-1:0] raw);
    logic [VW-1:0] v;
    v = VW'(raw);
    for (int k = NSTEP - 1; k >= 0; k--) begin
      if (v >= (VW'(MEM_WORDS) << k)) begin
        v = v - (VW'(MEM_WORDS) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  req_t              req_r, req_nxt;
  logic [AW-1:0]     wl_r, wl_nxt;
  logic [AW-1:0]     wh_r, wh_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_old_lo_r, out_old_lo_nxt;
  logic [DATA_W-1:0] out_old_hi_r, out_old_hi_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic                 out_free;
  logic [RAW_IDX_W-1:0] raw_lo;
  logic [AW-1:0]        wl_idx;
  logic [AW-1:0]        wh_idx;
  logic [1:0]           in_status;
  logic                 unsupported;
  logic                 misaligned;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] rd_lo;
  logic [DATA_W-1:0] rd_hi;
  alu_res_t          alu_res;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign out_valid  = out_valid_r;
  assign out_old_lo = out_old_lo_r;
  assign out_old_hi = out_old_hi_r;
  assign out_status = out_status_r;

  // Target word indices, taken straight from the request so that the read
  // issues in the cycle the request is accepted.
  assign raw_lo = {1'b0, in_address[ADDR_W-1:3]};
  assign wl_idx = reduce_idx(raw_lo);
  assign wh_idx = reduce_idx(raw_lo + RAW_IDX_W'(1));

  // The unsupported check has priority over the alignment check.
  always_comb begin
    unsupported = 1'b0;
    case (in_size_code)
      SIZE_32, SIZE_64: unsupported = (in_op == OP_READ);
      SIZE_128:         unsupported = (in_op == OP_FADD);
      default:          unsupported = 1'b1;
    endcase

    case (in_size_code)
      SIZE_32: misaligned = (in_address[1:0] != 2'd0);
      SIZE_64: misaligned = (in_address[2:0] != 3'd0);
      default: misaligned = (in_address[3:0] != 4'd0);
    endcase

    if (unsupported) begin
      in_status = STATUS_UNSUP;
    end else if (misaligned) begin
      in_status = STATUS_MISALIGN;
    end else begin
      in_status = STATUS_OK;
    end
  end

  amu_store #(
    .WORDS (MEM_WORDS)
  ) u_store (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (in_fire),
    .raddr0 (wl_idx),
    .raddr1 (wh_idx),
    .rdata0 (rd_lo),
    .rdata1 (rd_hi)
  );

  amu_alu u_alu (
    .req   (req_r),
    .rd_lo (rd_lo),
    .rd_hi (rd_hi),
    .res   (alu_res)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    req_nxt        = req_r;
    wl_nxt         = wl_r;
    wh_nxt         = wh_r;
    out_valid_nxt  = out_valid_r;
    out_old_lo_nxt = out_old_lo_r;
    out_old_hi_nxt = out_old_hi_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = wl_r;
    mem_wdata      = alu_res.new_lo;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        // Zero sweep of the store after reset.
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt.op        = in_op;
          req_nxt.size_code = in_size_code;
          req_nxt.lane_hi   = in_address[2];
          req_nxt.a_lo      = in_operand_a_lo;
          req_nxt.a_hi      = in_operand_a_hi;
          req_nxt.b_lo      = in_operand_b_lo;
          req_nxt.b_hi      = in_operand_b_hi;
          req_nxt.status    = in_status;
          wl_nxt            = wl_idx;
          wh_nxt            = wh_idx;
          state_nxt         = S_MOD;
        end
      end
      S_MOD: begin
        // Read data is valid here; the result register must be free to
        // finish, otherwise the step waits with the read data held.
        if (out_free) begin
          mem_we         = alu_res.wr_lo;
          mem_waddr      = wl_r;
          mem_wdata      = alu_res.new_lo;
          out_valid_nxt  = 1'b1;
          out_old_lo_nxt = alu_res.old_lo;
          out_old_hi_nxt = alu_res.old_hi;
          out_status_nxt = req_r.status;
          state_nxt      = alu_res.wr_hi ? S_WRH : S_IDLE;
        end
      end
      S_WRH: begin
        mem_we    = 1'b1;
        mem_waddr = wh_r;
        mem_wdata = alu_res.new_hi;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    wl_r         <= wl_nxt;
    wh_r         <= wh_nxt;
    out_old_lo_r <= out_old_lo_nxt;
    out_old_hi_r <= out_old_hi_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

/* hdl/amu_checker.sv */
module amu_checker import amu_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_old_lo,
  input logic [DATA_W-1:0] out_old_hi,
  input logic [1:0]        out_status
);

  // A stalled result stays in place unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_old_lo) &&
      $stable(out_old_hi) && $stable(out_status))
    else $error("stalled result changed");

  // A rejected request reports no data.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_old_lo == '0 && out_old_hi == '0)
    else $error("rejected request returned data");

  // Requests are worked on one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while one is in flight");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind fabric_atomic_memory_unit amu_checker u_amu_checker (.*);
